@@ rtl/core/smf_pkg.sv @@
package smf_pkg;

    localparam int SW = 24;

    typedef logic signed [SW-1:0] sample_t;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_FILL = 1'b1
    } cmd_t;

    typedef struct packed {
        logic    push;
        logic    fill;
        sample_t smp;
    } ctrl_t;

endpackage

@@ rtl/core/sliding_window_median_filter.sv @@
// Running median over the last WINDOW samples (signed 24-bit, 8 fraction bits).
// Input channel s_valid/s_ready carries s_cmd and s_sample. s_cmd = push enters
// the sample, drops the oldest one and yields one transfer on m_valid/m_ready
// carrying m_median; an even window gives the floor of the mean of the two
// middle values. s_cmd = fill loads every slot with s_sample and yields nothing.
// The window is a chain of WINDOW cells kept in ascending order; each cell
// holds one sample and its age and trades entries with its two neighbors, so
// the whole window is re-ranked in the cycle a push is taken.
// The median is registered and is on m_median in the cycle after the push transfer.
// Throughput: one item per cycle while m_ready is high; the single output
// register sets this figure.
// When the receiver stalls, s_ready is low as long as a median is waiting;
// nothing is dropped.
// Reset (aresetn low, synchronous) clears the window to zero and empties the
// output register; items are taken from the first cycle after reset.
module sliding_window_median_filter #(
    parameter int WINDOW = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [0:0]       s_cmd,
    input  smf_pkg::sample_t s_sample,
    output logic             m_valid,
    input  logic             m_ready,
    output smf_pkg::sample_t m_median
);
    import smf_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    ctrl_t             ctrl;
    logic              s_xfer;
    sample_t           val     [WINDOW];
    sample_t           val_nxt [WINDOW];
    logic [AW-1:0]     age     [WINDOW];
    logic [WINDOW-1:0] gt;
    logic [WINDOW-1:0] del;
    logic [WINDOW-1:0] ord_ok;
    logic [SW-1:0]     del_or;
    sample_t           del_val;

    assign s_ready   = aresetn && (!m_valid || m_ready);
    assign s_xfer    = s_valid && s_ready;
    assign ctrl.push = s_xfer && (s_cmd == CMD_PUSH);
    assign ctrl.fill = s_xfer && (s_cmd == CMD_FILL);
    assign ctrl.smp  = s_sample;

    always_comb begin
        del_or = '0;
        for (int i = 0; i < WINDOW; i++) begin
            del_or = del_or | (val[i] & {SW{del[i]}});
        end
    end
    assign del_val = sample_t'(del_or);

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        sample_t       p_val, n_val;
        logic [AW-1:0] p_age, n_age;
        logic          p_gt, n_gt;

        if (i == 0) begin : g_lo_end
            assign p_val     = '0;
            assign p_age     = '0;
            assign p_gt      = 1'b0;
            assign ord_ok[i] = 1'b1;
        end else begin : g_lo_nb
            assign p_val     = val[i-1];
            assign p_age     = age[i-1];
            assign p_gt      = gt[i-1];
            assign ord_ok[i] = val[i-1] <= val[i];
        end

        if (i == WINDOW - 1) begin : g_hi_end
            assign n_val = '0;
            assign n_age = '0;
            assign n_gt  = 1'b1;
        end else begin : g_hi_nb
            assign n_val = val[i+1];
            assign n_age = age[i+1];
            assign n_gt  = gt[i+1];
        end

        smf_cell #(
            .WINDOW (WINDOW),
            .IDX    (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .del_val (del_val),
            .prv_val (p_val),
            .prv_age (p_age),
            .prv_gt  (p_gt),
            .nxt_val (n_val),
            .nxt_age (n_age),
            .nxt_gt  (n_gt),
            .val     (val[i]),
            .age     (age[i]),
            .gt      (gt[i]),
            .del     (del[i]),
            .val_nxt (val_nxt[i])
        );
    end

    smf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctrl.push),
        .lo       (val_nxt[(WINDOW - 1) / 2]),
        .hi       (val_nxt[WINDOW / 2]),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_median (m_median)
    );

    a_one_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(del))
        else $error("window does not hold exactly one oldest entry");

    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        &ord_ok)
        else $error("cell chain out of ascending order");

    a_push_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> m_valid)
        else $error("push transfer produced no median");

    a_fill_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.fill && !m_valid) |=> !m_valid)
        else $error("fill produced a median");

endmodule

@@ rtl/core/smf_cell.sv @@
module smf_cell #(
    parameter int WINDOW = 64,
    parameter int IDX    = 0
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  smf_pkg::ctrl_t                               ctrl,
    input  smf_pkg::sample_t                             del_val,
    input  smf_pkg::sample_t                             prv_val,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] prv_age,
    input  logic                                         prv_gt,
    input  smf_pkg::sample_t                             nxt_val,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] nxt_age,
    input  logic                                         nxt_gt,
    output smf_pkg::sample_t                             val,
    output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] age,
    output logic                                         gt,
    output logic                                         del,
    output smf_pkg::sample_t                             val_nxt
);
    import smf_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam bit FIRST = (IDX == 0);
    localparam bit LAST  = (IDX == WINDOW - 1);
    localparam logic [AW-1:0] OLD_AGE  = AW'(WINDOW - 1);
    localparam logic [AW-1:0] FILL_AGE = AW'(WINDOW - 1 - IDX);

    sample_t         val_reg, val_next;
    logic [AW-1:0]   age_reg, age_next;
    sample_t         smp;
    logic            above;

    assign smp   = ctrl.smp;
    assign gt    = val_reg > smp;
    assign del   = age_reg == OLD_AGE;
    // equal values stay ordered oldest first, so the departing entry leads its group
    assign above = (val_reg > del_val) || ((val_reg == del_val) && !del);

    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.fill) begin
            val_next = smp;
            age_next = FILL_AGE;
        end else if (ctrl.push) begin
            age_next = age_reg + AW'(1);
            if (del) begin
                if (!FIRST && prv_gt) begin
                    val_next = prv_val;
                    age_next = prv_age + AW'(1);
                end else if (!LAST && !nxt_gt) begin
                    val_next = nxt_val;
                    age_next = nxt_age + AW'(1);
                end else begin
                    val_next = smp;
                    age_next = '0;
                end
            end else if (above) begin
                if (!LAST && !nxt_gt) begin
                    val_next = nxt_val;
                    age_next = nxt_age + AW'(1);
                end else if (!gt) begin
                    val_next = smp;
                    age_next = '0;
                end
            end else begin
                if (gt) begin
                    if (FIRST || !prv_gt) begin
                        val_next = smp;
                        age_next = '0;
                    end else begin
                        val_next = prv_val;
                        age_next = prv_age + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            age_reg <= FILL_AGE;
        end else begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val     = val_reg;
    assign age     = age_reg;
    assign val_nxt = val_next;

endmodule

@@ rtl/core/smf_out.sv @@
module smf_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  smf_pkg::sample_t lo,
    input  smf_pkg::sample_t hi,
    input  logic             m_ready,
    output logic             m_valid,
    output smf_pkg::sample_t m_median
);
    import smf_pkg::*;

    logic signed [SW:0] sum;
    sample_t            median_reg, median_next;
    logic               valid_reg, valid_next;

    // floor of the mean; equals lo when both middle taps are the same cell
    assign sum         = {lo[SW-1], lo} + {hi[SW-1], hi};
    assign median_next = load ? sample_t'(sum[SW:1]) : median_reg;
    assign valid_next  = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        median_reg <= median_next;
    end

    assign m_valid  = valid_reg;
    assign m_median = median_reg;

endmodule

@@ test/sliding_window_median_filter_tb.sv @@
module sliding_window_median_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int WIN     = 64;
    localparam int N_ITEMS = 900;

    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;
    localparam sample_t S_NEG1 = 24'shFFFFFF;

    typedef struct packed {
        cmd_t    cmd;
        sample_t smp;
        logic    typed;
        sample_t med;
    } dir_row_t;

    localparam int NDIR = 22;

    // typed medians: window dominated by the fill value, or all zeros after reset
    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{CMD_PUSH, S_MAX,         1'b1, 24'sh000000},
        '{CMD_PUSH, S_MIN,         1'b1, 24'sh000000},
        '{CMD_PUSH, 24'sh000000,   1'b1, 24'sh000000},
        '{CMD_FILL, S_MAX,         1'b0, 24'sh000000},
        '{CMD_PUSH, S_MAX,         1'b1, S_MAX},
        '{CMD_PUSH, S_MIN,         1'b1, S_MAX},
        '{CMD_FILL, S_MIN,         1'b0, 24'sh000000},
        '{CMD_PUSH, S_MIN,         1'b1, S_MIN},
        '{CMD_PUSH, S_MAX,         1'b1, S_MIN},
        '{CMD_FILL, S_NEG1,        1'b0, 24'sh000000},
        '{CMD_PUSH, 24'sh000000,   1'b1, S_NEG1},
        '{CMD_PUSH, 24'sh000001,   1'b1, S_NEG1},
        '{CMD_FILL, 24'sh000100,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'shFFFF00,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'sh555555,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'shAAAAAA,   1'b0, 24'sh000000},
        '{CMD_FILL, 24'sh123456,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'sh123456,   1'b1, 24'sh123456},
        '{CMD_FILL, 24'sh000000,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'sh000001,   1'b0, 24'sh000000},
        '{CMD_PUSH, 24'shFFFFFE,   1'b0, 24'sh000000},
        '{CMD_PUSH, S_MAX,         1'b0, 24'sh000000}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_valid  = 1'b0;
    logic       s_ready;
    logic [0:0] s_cmd    = CMD_PUSH;
    sample_t    s_sample = '0;
    logic       m_valid;
    logic       m_ready  = 1'b0;
    sample_t    m_median;

    sample_t win_model [WIN];
    int      win_oldest;
    sample_t exp_medians [$];

    int errors       = 0;
    int n_sent       = 0;
    int medians_seen = 0;
    int burst_left   = 0;

    sliding_window_median_filter #(
        .WINDOW(WIN)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_sample (s_sample),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_median (m_median)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic sample_t median_of_window();
        sample_t srt [WIN];
        sample_t key;
        int i;
        int j;
        logic signed [SW:0] pair_sum;
        srt = win_model;
        for (i = 1; i < WIN; i++) begin
            key = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > key) begin
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = key;
        end
        if (WIN % 2 == 0) begin
            // exact 25-bit sum, floor halving
            pair_sum = srt[WIN/2 - 1] + srt[WIN/2];
            return pair_sum[SW:1];
        end
        return srt[WIN/2];
    endfunction

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        return $urandom_range(1, 6);
    endfunction

    function automatic sample_t pick_value(sample_t base);
        sample_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = base + sample_t'($urandom_range(0, 64)) - sample_t'(32);
            4, 5, 6:    v = sample_t'($urandom);
            7:          v = S_MAX;
            8:          v = S_MIN;
            default:    v = base;
        endcase
        return v;
    endfunction

    task automatic send_item(input cmd_t cmd, input sample_t smp, input bit typed,
                             input sample_t med);
        int i;
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        if (cmd == CMD_FILL) begin
            for (i = 0; i < WIN; i++) win_model[i] = smp;
            win_oldest = 0;
        end else begin
            win_model[win_oldest] = smp;
            win_oldest = (win_oldest + 1) % WIN;
            exp_medians.push_back(typed ? med : median_of_window());
        end
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (exp_medians.size() != 0) @(posedge aclk);
    endtask

    // receiver: checks transfers, stalls on its own mode pattern
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        int cyc;
        sample_t want;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (aresetn && m_valid && m_ready) begin
                medians_seen++;
                if (exp_medians.size() == 0) begin
                    $error("median transfer with nothing expected: actual %0d", m_median);
                    errors++;
                end else begin
                    want = exp_medians.pop_front();
                    if (m_median !== want) begin
                        $error("median mismatch: expected %0d, actual %0d", want, m_median);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && medians_seen >= 150) begin
                // long hold-off while the sender keeps offering
                hold_done = 1;
                hold_left = 300;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        int k;
        int run;
        int kind;
        int i;
        bit mid_pause_done;
        sample_t base;

        mid_pause_done = 0;
        for (i = 0; i < WIN; i++) win_model[i] = '0;
        win_oldest = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < NDIR; k++) begin
            send_item(DIR_TAB[k].cmd, DIR_TAB[k].smp, DIR_TAB[k].typed, DIR_TAB[k].med);
            sender_gap(next_gap());
        end
        wait_drained();

        while (n_sent < N_ITEMS) begin
            if (!mid_pause_done && n_sent >= N_ITEMS / 2) begin
                mid_pause_done = 1;
                wait_drained();
            end
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                base = sample_t'($urandom);
                send_item(CMD_FILL, base, 1'b0, '0);
                sender_gap(next_gap());
                run = $urandom_range(1, 90);
                for (i = 0; i < run; i++) begin
                    send_item(CMD_PUSH, pick_value(base), 1'b0, '0);
                    sender_gap(next_gap());
                end
            end else if (kind < 19) begin
                run = $urandom_range(1, 20);
                for (i = 0; i < run; i++) begin
                    send_item(CMD_PUSH, sample_t'($urandom), 1'b0, '0);
                    sender_gap(next_gap());
                end
            end else begin
                send_item(CMD_FILL, sample_t'($urandom), 1'b0, '0);
                sender_gap(next_gap());
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sliding_window_median_filter.f @@
rtl/core/smf_pkg.sv
rtl/core/smf_cell.sv
rtl/core/smf_out.sv
rtl/core/sliding_window_median_filter.sv
test/sliding_window_median_filter_tb.sv
